[rtl/core/ts_keyframe_window_classifier_unit_defines.svh]
// assertion macros for the keyframe window classifier
// used by the top level; needs clk and rst_n in the including scope
`ifndef TS_KEYFRAME_WINDOW_CLASSIFIER_UNIT_DEFINES_SVH
`define TS_KEYFRAME_WINDOW_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TSKWC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TSKWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tskwc_pkg.sv]
// types, constants and helpers for the keyframe window classifier
// no dependencies
package tskwc_pkg;

    localparam int OFFSET_W    = 48;
    localparam int PID_W       = 13;
    localparam int STAMP_W     = 33;
    localparam int TIME_W      = 37;
    localparam int QUOT_W      = 30;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 37;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_REQUIRE_FLAG = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_PTS     = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_VALID   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_TIME   = 4'd3;

    // floor(2^33 / 9): quotient estimate is low by at most one
    localparam logic [QUOT_W-1:0] RECIP_NINE = 30'd954437176;
    localparam int                RECIP_SHIFT = 33;
    localparam logic [4:0]        NINE = 5'd9;

    localparam logic [PID_W-1:0]  PAT_PID = 13'd0;

    typedef struct packed {
        logic                window_start;
        logic [OFFSET_W-1:0] packet_offset;
        logic                sync_ok;
        logic [PID_W-1:0]    packet_pid;
        logic                unit_start;
        logic                video_with_pts;
        logic                random_access;
        logic [STAMP_W-1:0]  stamp;
    } packet_t;

    typedef struct packed {
        logic                window_any;
        logic [OFFSET_W-1:0] first_offset;
        logic [TIME_W-1:0]   first_time;
        logic                best_found;
        logic [OFFSET_W-1:0] best_offset;
        logic [TIME_W-1:0]   best_time;
        logic                past_limit;
    } result_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
    } cfg_write_t;

    // floor(r * 100 / 9) for a remainder r below nine
    function automatic logic [6:0] frac_time(input logic [3:0] r);
        logic [6:0] f;
        case (r)
            4'd0:    f = 7'd0;
            4'd1:    f = 7'd11;
            4'd2:    f = 7'd22;
            4'd3:    f = 7'd33;
            4'd4:    f = 7'd44;
            4'd5:    f = 7'd55;
            4'd6:    f = 7'd66;
            4'd7:    f = 7'd77;
            4'd8:    f = 7'd88;
            default: f = 7'd0;
        endcase
        return f;
    endfunction

endpackage

[rtl/core/tskwc_stream_if.sv]
// valid/ready channel carrying one payload item per transfer
// payload type is set at instantiation, usually from tskwc_pkg
interface tskwc_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/ts_keyframe_window_classifier_unit.sv]
// Throughput: one packet per cycle; stages stall only when the result register is held.
// The time path is a 33x30 constant multiply for the divide by nine, then one correction.
// Window state is updated in the last stage, so packet n+1 sees packet n's summary.
// Reset clears all stage valids, the window summary and the registers to their defaults.
// Depends on tskwc_pkg, tskwc_stream_if and the assertion macro header.
`include "ts_keyframe_window_classifier_unit_defines.svh"

module ts_keyframe_window_classifier_unit #(
    parameter int PACKET_BYTES      = 188,
    parameter int PAT_REACH_PACKETS = 16,
    parameter int OFFSET_BITS       = 48
) (
    input logic           clk,
    input logic           rst_n,
    tskwc_stream_if.sink   pkt_in,
    tskwc_stream_if.source result_out,
    tskwc_stream_if.sink   cfg
);

    localparam int OFF_W = (OFFSET_BITS < tskwc_pkg::OFFSET_W) ?
                           OFFSET_BITS : tskwc_pkg::OFFSET_W;
    // pat distance wraps at the full offset width, which may exceed the stored width
    localparam int DIST_W = OFFSET_BITS;
    localparam logic [DIST_W-1:0] REACH = DIST_W'(PAT_REACH_PACKETS * PACKET_BYTES);
    localparam int ST_W = tskwc_pkg::STAMP_W;
    localparam int TM_W = tskwc_pkg::TIME_W;
    localparam int Q_W  = tskwc_pkg::QUOT_W;

    // configuration registers
    logic            require_flag_reg;
    logic [ST_W-1:0] base_pts_reg;
    logic            base_valid_reg;
    logic [TM_W-1:0] limit_time_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            require_flag_reg <= 1'b0;
            base_pts_reg     <= '0;
            base_valid_reg   <= 1'b0;
            limit_time_reg   <= '1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                tskwc_pkg::REG_REQUIRE_FLAG: require_flag_reg <= cfg.data.value[0];
                tskwc_pkg::REG_BASE_PTS:     base_pts_reg     <= cfg.data.value[ST_W-1:0];
                tskwc_pkg::REG_BASE_VALID:   base_valid_reg   <= cfg.data.value[0];
                tskwc_pkg::REG_LIMIT_TIME:   limit_time_reg   <= cfg.data.value[TM_W-1:0];
                default:                     ;
            endcase
        end
    end

    // stage flow control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic out_free, s4_free, s3_free, s2_free, s1_free, s4_move;

    assign out_free = !out_valid_reg || result_out.ready;
    assign s4_free  = !s4_valid_reg || out_free;
    assign s3_free  = !s3_valid_reg || s4_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s4_move  = s4_valid_reg && out_free;
    assign pkt_in.ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)  s1_valid_reg  <= pkt_in.valid;
            if (s2_free)  s2_valid_reg  <= s1_valid_reg;
            if (s3_free)  s3_valid_reg  <= s2_valid_reg;
            if (s4_free)  s4_valid_reg  <= s3_valid_reg;
            if (out_free) out_valid_reg <= s4_valid_reg;
        end
    end

    // packet classification fields, carried down the pipe
    logic             s1_start_reg, s2_start_reg, s3_start_reg, s4_start_reg;
    logic [OFF_W-1:0] s1_off_reg, s2_off_reg, s3_off_reg, s4_off_reg;
    logic             s1_pat_reg, s2_pat_reg, s3_pat_reg, s4_pat_reg;
    logic             s1_vid_reg, s2_vid_reg, s3_vid_reg, s4_vid_reg;
    logic             s1_rai_reg, s2_rai_reg, s3_rai_reg, s4_rai_reg;
    logic             in_pat;

    assign in_pat = pkt_in.data.sync_ok && pkt_in.data.unit_start &&
                    (pkt_in.data.packet_pid == tskwc_pkg::PAT_PID);

    // stage 1: classify and take the stamp difference
    logic [ST_W-1:0] s1_diff_reg;

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_start_reg <= pkt_in.data.window_start;
            s1_off_reg   <= pkt_in.data.packet_offset[OFF_W-1:0];
            s1_pat_reg   <= in_pat;
            s1_vid_reg   <= pkt_in.data.sync_ok && !in_pat && pkt_in.data.video_with_pts;
            s1_rai_reg   <= pkt_in.data.random_access;
            s1_diff_reg  <= pkt_in.data.stamp - base_pts_reg;
        end
    end

    // stage 2: quotient estimate by reciprocal multiply
    logic [ST_W+Q_W-1:0] s2_prod;
    logic [ST_W-1:0]     s2_diff_reg;
    logic [Q_W-1:0]      s2_qest_reg;

    assign s2_prod = (ST_W+Q_W)'(s1_diff_reg) * (ST_W+Q_W)'(tskwc_pkg::RECIP_NINE);

    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            s2_start_reg <= s1_start_reg;
            s2_off_reg   <= s1_off_reg;
            s2_pat_reg   <= s1_pat_reg;
            s2_vid_reg   <= s1_vid_reg;
            s2_rai_reg   <= s1_rai_reg;
            s2_diff_reg  <= s1_diff_reg;
            s2_qest_reg  <= s2_prod[ST_W+Q_W-1:tskwc_pkg::RECIP_SHIFT];
        end
    end

    // stage 3: remainder and one-step correction; remainder stays below 18
    logic [4:0]     s3_nine_q;
    logic [4:0]     s3_rem;
    logic           s3_fix;
    logic [Q_W-1:0] s3_q_reg;
    logic [3:0]     s3_r_reg;

    assign s3_nine_q = {s2_qest_reg[1:0], 3'b000} + s2_qest_reg[4:0];
    assign s3_rem    = s2_diff_reg[4:0] - s3_nine_q;
    assign s3_fix    = (s3_rem >= tskwc_pkg::NINE);

    always_ff @(posedge clk)
    begin
        if (s3_free)
        begin
            s3_start_reg <= s2_start_reg;
            s3_off_reg   <= s2_off_reg;
            s3_pat_reg   <= s2_pat_reg;
            s3_vid_reg   <= s2_vid_reg;
            s3_rai_reg   <= s2_rai_reg;
            s3_q_reg     <= s3_fix ? (s2_qest_reg + 1'b1) : s2_qest_reg;
            s3_r_reg     <= s3_fix ? 4'(s3_rem - tskwc_pkg::NINE) : s3_rem[3:0];
        end
    end

    // stage 4: time = q * 100 + floor(r * 100 / 9)
    logic [TM_W-1:0] s4_time_calc;
    logic [TM_W-1:0] s4_time_reg;

    assign s4_time_calc = TM_W'({s3_q_reg, 6'b0}) + TM_W'({s3_q_reg, 5'b0}) +
                          TM_W'({s3_q_reg, 2'b0}) + TM_W'(tskwc_pkg::frac_time(s3_r_reg));

    always_ff @(posedge clk)
    begin
        if (s4_free)
        begin
            s4_start_reg <= s3_start_reg;
            s4_off_reg   <= s3_off_reg;
            s4_pat_reg   <= s3_pat_reg;
            s4_vid_reg   <= s3_vid_reg;
            s4_rai_reg   <= s3_rai_reg;
            s4_time_reg  <= base_valid_reg ? s4_time_calc : '0;
        end
    end

    // window summary state, also the result payload
    logic             pat_seen_reg, pat_seen_next;
    logic [OFF_W-1:0] pat_off_reg, pat_off_next;
    logic             any_flag_reg, any_flag_next;
    logic [OFF_W-1:0] first_off_reg, first_off_next;
    logic [TM_W-1:0]  first_time_reg, first_time_next;
    logic             best_flag_reg, best_flag_next;
    logic [OFF_W-1:0] best_off_reg, best_off_next;
    logic [TM_W-1:0]  best_time_reg, best_time_next;
    logic             after_flag_reg, after_flag_next;

    logic [DIST_W-1:0] pat_gap;
    logic              near;
    logic              key;
    logic [OFF_W-1:0]  entry_pos;

    // stage 5: window update with start clearing applied first
    always_comb
    begin
        pat_seen_next   = s4_start_reg ? 1'b0 : pat_seen_reg;
        pat_off_next    = s4_start_reg ? '0 : pat_off_reg;
        any_flag_next   = s4_start_reg ? 1'b0 : any_flag_reg;
        first_off_next  = s4_start_reg ? '0 : first_off_reg;
        first_time_next = s4_start_reg ? '0 : first_time_reg;
        best_flag_next  = s4_start_reg ? 1'b0 : best_flag_reg;
        best_off_next   = s4_start_reg ? '0 : best_off_reg;
        best_time_next  = s4_start_reg ? '0 : best_time_reg;
        after_flag_next = s4_start_reg ? 1'b0 : after_flag_reg;

        pat_gap   = DIST_W'(s4_off_reg) - DIST_W'(pat_off_next);
        near      = pat_seen_next && (pat_gap <= REACH);
        key       = s4_vid_reg && (require_flag_reg ? s4_rai_reg : near);
        entry_pos = near ? pat_off_next : s4_off_reg;

        if (s4_pat_reg)
        begin
            pat_seen_next = 1'b1;
            pat_off_next  = s4_off_reg;
        end
        else if (key)
        begin
            pat_seen_next = 1'b0;
            pat_off_next  = '0;
            if (!any_flag_next)
            begin
                any_flag_next   = 1'b1;
                first_off_next  = entry_pos;
                first_time_next = s4_time_reg;
            end
            if (s4_time_reg <= limit_time_reg)
            begin
                if (!best_flag_next || (s4_time_reg >= best_time_next))
                begin
                    best_flag_next = 1'b1;
                    best_off_next  = entry_pos;
                    best_time_next = s4_time_reg;
                end
            end
            else
            begin
                after_flag_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_seen_reg   <= 1'b0;
            pat_off_reg    <= '0;
            any_flag_reg   <= 1'b0;
            first_off_reg  <= '0;
            first_time_reg <= '0;
            best_flag_reg  <= 1'b0;
            best_off_reg   <= '0;
            best_time_reg  <= '0;
            after_flag_reg <= 1'b0;
        end
        else if (s4_move)
        begin
            pat_seen_reg   <= pat_seen_next;
            pat_off_reg    <= pat_off_next;
            any_flag_reg   <= any_flag_next;
            first_off_reg  <= first_off_next;
            first_time_reg <= first_time_next;
            best_flag_reg  <= best_flag_next;
            best_off_reg   <= best_off_next;
            best_time_reg  <= best_time_next;
            after_flag_reg <= after_flag_next;
        end
    end

    // result transfer: summary registers hold while the result waits
    assign result_out.valid             = out_valid_reg;
    assign result_out.data.window_any   = any_flag_reg;
    assign result_out.data.first_offset = tskwc_pkg::OFFSET_W'(first_off_reg);
    assign result_out.data.first_time   = first_time_reg;
    assign result_out.data.best_found   = best_flag_reg;
    assign result_out.data.best_offset  = tskwc_pkg::OFFSET_W'(best_off_reg);
    assign result_out.data.best_time    = best_time_reg;
    assign result_out.data.past_limit   = after_flag_reg;

    // checks on the window summary and the divide path
    `TSKWC_ASSERT_IMPLY(a_best_needs_any, best_flag_reg, any_flag_reg,
        "best candidate recorded without any candidate")
    `TSKWC_ASSERT_IMPLY(a_first_zero, !any_flag_reg,
        (first_off_reg == '0) && (first_time_reg == '0),
        "first candidate fields not cleared")
    `TSKWC_ASSERT_IMPLY(a_pat_zero, !pat_seen_reg, pat_off_reg == '0,
        "stale PAT offset kept")
    `TSKWC_ASSERT_IMPLY(a_rem_range, s4_valid_reg && s4_free && s3_valid_reg,
        s3_r_reg < 4'd9, "divide remainder out of range")
    `TSKWC_ASSERT_NEXT(a_hold_summary, !s4_move,
        $stable(best_time_reg) && $stable(first_off_reg) && $stable(any_flag_reg),
        "window summary changed without a packet")

endmodule

[dv/tb_top.sv]
// testbench for ts_keyframe_window_classifier_unit: directed and random packet streams
// checked against a window summary predictor; needs tskwc_pkg and tskwc_stream_if
module tb_top;

    localparam int          PACKET_BYTES      = 188;
    localparam int          PAT_REACH_PACKETS = 16;
    localparam int          OFFSET_BITS       = 48;
    localparam logic [47:0] REACH_BYTES       = 48'(PAT_REACH_PACKETS * PACKET_BYTES);
    localparam int          SETTLE_CYCLES     = 8;
    localparam int          PACKET_W          = $bits(tskwc_pkg::packet_t);

    // predicts the window summary after every accepted packet and checks results
    class window_summary_tracker;
        bit                                require_flag;
        bit [tskwc_pkg::STAMP_W-1:0]       base_pts;
        bit                                base_valid;
        bit [tskwc_pkg::TIME_W-1:0]        limit_time;
        bit [47:0]                         reach;

        bit                                pat_seen;
        bit [47:0]                         pat_off;
        bit                                any_seen;
        bit [47:0]                         first_pos;
        bit [tskwc_pkg::TIME_W-1:0]        first_tm;
        bit                                best_seen;
        bit [47:0]                         best_pos;
        bit [tskwc_pkg::TIME_W-1:0]        best_tm;
        bit                                above_limit;

        tskwc_pkg::result_t                summary_q[$];
        int                                errors;

        function new(bit [47:0] reach_bytes);
            reach        = reach_bytes;
            require_flag = 1'b0;
            base_pts     = '0;
            base_valid   = 1'b0;
            limit_time   = '1;
            errors       = 0;
            clear_window();
        endfunction

        function void clear_window();
            pat_seen    = 1'b0;
            pat_off     = '0;
            any_seen    = 1'b0;
            first_pos   = '0;
            first_tm    = '0;
            best_seen   = 1'b0;
            best_pos    = '0;
            best_tm     = '0;
            above_limit = 1'b0;
        endfunction

        function void write_reg(logic [tskwc_pkg::CFG_INDEX_W-1:0] idx,
                                logic [tskwc_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                tskwc_pkg::REG_REQUIRE_FLAG: require_flag = value[0];
                tskwc_pkg::REG_BASE_PTS:     base_pts     = value[tskwc_pkg::STAMP_W-1:0];
                tskwc_pkg::REG_BASE_VALID:   base_valid   = value[0];
                tskwc_pkg::REG_LIMIT_TIME:   limit_time   = value[tskwc_pkg::TIME_W-1:0];
                default:                     ;
            endcase
        endfunction

        // microseconds from the base: wrapped 90 kHz difference times 100 over 9
        function bit [tskwc_pkg::TIME_W-1:0] stamp_micros(bit [tskwc_pkg::STAMP_W-1:0] stamp);
            bit [tskwc_pkg::STAMP_W-1:0] delta;
            bit [47:0]                   scaled;
            if (!base_valid)
                return '0;
            delta  = stamp - base_pts;
            scaled = (48'(delta) * 48'd100) / 48'd9;
            return scaled[tskwc_pkg::TIME_W-1:0];
        endfunction

        function int pending();
            return summary_q.size();
        endfunction

        function void note_packet(tskwc_pkg::packet_t p);
            bit [47:0]                  gap;
            bit                         near_pat;
            bit                         is_key;
            bit [47:0]                  entry_pos;
            bit [tskwc_pkg::TIME_W-1:0] entry_tm;
            tskwc_pkg::result_t         r;
            if (p.window_start)
                clear_window();
            if (p.sync_ok)
            begin
                // a pat start wins over a video flag
                if (p.packet_pid == tskwc_pkg::PAT_PID && p.unit_start)
                begin
                    pat_seen = 1'b1;
                    pat_off  = p.packet_offset;
                end
                else if (p.video_with_pts)
                begin
                    gap      = p.packet_offset - pat_off;
                    near_pat = pat_seen && (gap <= reach);
                    is_key   = require_flag ? p.random_access : near_pat;
                    if (is_key)
                    begin
                        entry_pos = near_pat ? pat_off : p.packet_offset;
                        entry_tm  = stamp_micros(p.stamp);
                        pat_seen  = 1'b0;
                        pat_off   = '0;
                        if (!any_seen)
                        begin
                            any_seen  = 1'b1;
                            first_pos = entry_pos;
                            first_tm  = entry_tm;
                        end
                        // ties go to the later candidate
                        if (entry_tm <= limit_time)
                        begin
                            if (!best_seen || entry_tm >= best_tm)
                            begin
                                best_seen = 1'b1;
                                best_pos  = entry_pos;
                                best_tm   = entry_tm;
                            end
                        end
                        else
                        begin
                            above_limit = 1'b1;
                        end
                    end
                end
            end
            r.window_any   = any_seen;
            r.first_offset = first_pos;
            r.first_time   = first_tm;
            r.best_found   = best_seen;
            r.best_offset  = best_pos;
            r.best_time    = best_tm;
            r.past_limit   = above_limit;
            summary_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_summary(tskwc_pkg::result_t got);
            tskwc_pkg::result_t want;
            if (summary_q.size() == 0)
            begin
                $error("window summary transfer with no packet outstanding");
                errors++;
                return;
            end
            want = summary_q.pop_front();
            compare_field("window_any",   64'(want.window_any),   64'(got.window_any));
            compare_field("first_offset", 64'(want.first_offset), 64'(got.first_offset));
            compare_field("first_time",   64'(want.first_time),   64'(got.first_time));
            compare_field("best_found",   64'(want.best_found),   64'(got.best_found));
            compare_field("best_offset",  64'(want.best_offset),  64'(got.best_offset));
            compare_field("best_time",    64'(want.best_time),    64'(got.best_time));
            compare_field("past_limit",   64'(want.past_limit),   64'(got.past_limit));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tskwc_stream_if #(.data_t(tskwc_pkg::packet_t))    pkt_if ();
    tskwc_stream_if #(.data_t(tskwc_pkg::result_t))    result_if ();
    tskwc_stream_if #(.data_t(tskwc_pkg::cfg_write_t)) cfg_if ();

    ts_keyframe_window_classifier_unit #(
        .PACKET_BYTES      (PACKET_BYTES),
        .PAT_REACH_PACKETS (PAT_REACH_PACKETS),
        .OFFSET_BITS       (OFFSET_BITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_in     (pkt_if.sink),
        .result_out (result_if.source),
        .cfg        (cfg_if.sink)
    );

    window_summary_tracker summary = new(REACH_BYTES);

    int                            send_idle_pct = 0;
    int                            recv_idle_pct = 0;
    logic [47:0]                   offset_cursor;
    logic [tskwc_pkg::STAMP_W-1:0] stamp_origin;
    int unsigned                   stamp_span;

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side backpressure
    always @(posedge clk)
    begin
        result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // note accepted packets and check accepted summaries
    always @(posedge clk)
    begin
        if (rst_n && pkt_if.valid && pkt_if.ready)
            summary.note_packet(pkt_if.data);
        if (rst_n && result_if.valid && result_if.ready)
            summary.check_summary(result_if.data);
    end

    function automatic tskwc_pkg::packet_t mk_packet(logic start, logic [47:0] off,
                                                     logic sync,
                                                     logic [tskwc_pkg::PID_W-1:0] pid,
                                                     logic pusi, logic vpts, logic rai,
                                                     logic [tskwc_pkg::STAMP_W-1:0] stamp);
        tskwc_pkg::packet_t p;
        p.window_start   = start;
        p.packet_offset  = off;
        p.sync_ok        = sync;
        p.packet_pid     = pid;
        p.unit_start     = pusi;
        p.video_with_pts = vpts;
        p.random_access  = rai;
        p.stamp          = stamp;
        return p;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // mostly well-formed streams: pat then video packets at packet spacing
    function automatic tskwc_pkg::packet_t make_random_packet();
        tskwc_pkg::packet_t p;
        int unsigned        kind;
        int unsigned        pick;
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        if (pick < 3)
            offset_cursor = offset_cursor - 48'(PACKET_BYTES * $urandom_range(1, 5));
        else if (pick < 5)
            offset_cursor = 48'(rand64());
        else
            offset_cursor = offset_cursor + 48'(PACKET_BYTES * $urandom_range(1, 20));
        p.window_start   = ($urandom_range(0, 24) == 0);
        p.packet_offset  = offset_cursor;
        p.sync_ok        = ($urandom_range(0, 19) != 0);
        p.random_access  = ($urandom_range(0, 9) < 7);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            p.stamp = tskwc_pkg::STAMP_W'(rand64());
        else if (pick < 25)
            p.stamp = stamp_origin;
        else
            p.stamp = stamp_origin + tskwc_pkg::STAMP_W'($urandom_range(0, stamp_span));
        if (kind < 5)
        begin
            // noise
            p = PACKET_W'({rand64(), rand64()});
            p.packet_offset = 48'(rand64());
            p.stamp         = tskwc_pkg::STAMP_W'(rand64());
        end
        else if (kind < 30)
        begin
            p.packet_pid     = tskwc_pkg::PAT_PID;
            p.unit_start     = 1'b1;
            p.video_with_pts = 1'($urandom_range(0, 1));
        end
        else if (kind < 65)
        begin
            p.packet_pid     = tskwc_pkg::PID_W'($urandom_range(1, 8191));
            p.unit_start     = 1'($urandom_range(0, 1));
            p.video_with_pts = 1'b1;
        end
        else
        begin
            p.packet_pid     = tskwc_pkg::PID_W'($urandom_range(0, 8191));
            p.unit_start     = (p.packet_pid == tskwc_pkg::PAT_PID) ?
                               1'b0 : 1'($urandom_range(0, 1));
            p.video_with_pts = 1'b0;
        end
        return p;
    endfunction

    task automatic send_packet(tskwc_pkg::packet_t p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pkt_if.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_if.valid <= 1'b1;
        pkt_if.data  <= p;
        @(posedge clk);
        while (!pkt_if.ready)
            @(posedge clk);
    endtask

    // stop sending and let every summary come back
    task automatic drain();
        pkt_if.valid <= 1'b0;
        while (summary.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_transfer(logic [tskwc_pkg::CFG_INDEX_W-1:0] idx,
                                logic [tskwc_pkg::CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, value: value};
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        summary.write_reg(idx, value);
    endtask

    // all four registers plus one write to an unused index
    task automatic apply_settings(logic rf, logic [tskwc_pkg::STAMP_W-1:0] base, logic bv,
                                  logic [tskwc_pkg::TIME_W-1:0] limit);
        cfg_transfer(tskwc_pkg::REG_REQUIRE_FLAG, {36'(rand64()), rf});
        cfg_transfer(tskwc_pkg::REG_BASE_PTS, {4'($urandom()), base});
        cfg_transfer(tskwc_pkg::REG_BASE_VALID, {36'(rand64()), bv});
        cfg_transfer(tskwc_pkg::REG_LIMIT_TIME, limit);
        cfg_transfer(tskwc_pkg::CFG_INDEX_W'($urandom_range(4, 15)),
                     tskwc_pkg::CFG_DATA_W'(rand64()));
        cfg_if.valid <= 1'b0;
        stamp_origin = base;
    endtask

    task automatic run_random(int count);
        offset_cursor = ($urandom_range(0, 1) != 0) ? 48'(rand64()) : 48'd0;
        repeat (count) send_packet(make_random_packet());
        drain();
    endtask

    initial
    begin
        tskwc_pkg::packet_t            directed_q[$];
        logic [tskwc_pkg::STAMP_W-1:0] span_base;

        rst_n           <= 1'b0;
        pkt_if.valid    <= 1'b0;
        pkt_if.data     <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.data     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles less than receiver
        send_idle_pct = 36;
        recv_idle_pct = 63;

        // reset settings: times read zero, pat reach decides candidates
        directed_q.push_back(mk_packet(1, 0, 1, tskwc_pkg::PAT_PID, 1, 0, 0, 0));
        directed_q.push_back(mk_packet(0, 3008, 1, 13'h100, 1, 1, 0, '1));
        directed_q.push_back(mk_packet(0, 3196, 1, 13'h100, 1, 1, 1, 5));
        directed_q.push_back(mk_packet(0, '1, 1, tskwc_pkg::PAT_PID, 1, 1, 1, 7));
        directed_q.push_back(mk_packet(0, 3007, 1, 13'h1FFF, 0, 1, 0, 9));
        directed_q.push_back(mk_packet(0, 10000, 1, tskwc_pkg::PAT_PID, 1, 0, 0, 0));
        directed_q.push_back(mk_packet(0, 9999, 1, 13'h100, 1, 1, 0, 0));
        directed_q.push_back(mk_packet(0, 13009, 1, 13'h100, 1, 1, 0, 0));
        directed_q.push_back(mk_packet(0, 20000, 0, tskwc_pkg::PAT_PID, 1, 0, 0, 0));
        directed_q.push_back(mk_packet(0, 12000, 0, 13'h100, 1, 1, 1, 0));
        directed_q.push_back(mk_packet(0, 12500, 1, 13'h1FFF, 1, 0, 1, '1));
        directed_q.push_back(mk_packet(0, 12600, 1, 13'h100, 1, 1, 0, 0));
        directed_q.push_back(mk_packet(0, 12788, 1, 13'h100, 1, 1, 0, 0));
        directed_q.push_back(mk_packet(0, 20000, 1, tskwc_pkg::PAT_PID, 0, 1, 0, 0));
        directed_q.push_back(mk_packet(0, 30000, 1, tskwc_pkg::PAT_PID, 1, 0, 0, 0));
        directed_q.push_back(mk_packet(1, 30188, 1, 13'h100, 1, 1, 0, 0));
        foreach (directed_q[i]) send_packet(directed_q[i]);
        drain();

        // flag mode, base just below the wrap, limit hit exactly by a 100 tick delta
        apply_settings(1'b1, 33'h1_FFFF_FF9C, 1'b1, 37'd1111);
        directed_q.delete();
        directed_q.push_back(mk_packet(1, 40000, 1, 13'h44, 1, 1, 1, 0));
        directed_q.push_back(mk_packet(0, 40188, 1, 13'h44, 1, 1, 1, 1));
        directed_q.push_back(mk_packet(0, 40376, 1, 13'h44, 1, 1, 1, '1));
        directed_q.push_back(mk_packet(0, 40564, 1, 13'h44, 1, 1, 1, 0));
        directed_q.push_back(mk_packet(0, 40752, 1, tskwc_pkg::PAT_PID, 1, 0, 0, 0));
        directed_q.push_back(mk_packet(0, 40940, 1, 13'h44, 1, 1, 0, 0));
        directed_q.push_back(mk_packet(0, 41128, 1, 13'h44, 1, 1, 1, 33'h1_FFFF_FF9C));
        directed_q.push_back(mk_packet(0, 41316, 1, 13'h44, 1, 0, 1, 0));
        foreach (directed_q[i]) send_packet(directed_q[i]);
        drain();

        // random base, limit near the middle of the stamp spread
        stamp_span = $urandom_range(1000, 2000000);
        span_base  = tskwc_pkg::STAMP_W'(rand64());
        apply_settings(1'b0, span_base, 1'b1,
                       tskwc_pkg::TIME_W'(stamp_span) * 37'd100 / 37'd18);
        run_random(250);

        // receiver idles less than sender
        send_idle_pct = 63;
        recv_idle_pct = 36;

        // largest base, zero limit
        stamp_span = 1000;
        apply_settings(1'b1, '1, 1'b1, '0);
        run_random(150);

        // times off, widest limit
        stamp_span = $urandom_range(1000, 2000000);
        apply_settings(1'b0, '0, 1'b0, '1);
        run_random(100);

        // back to back on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stamp_span = $urandom_range(1000, 100000000);
        span_base  = tskwc_pkg::STAMP_W'(rand64());
        apply_settings(1'($urandom_range(0, 1)), span_base, 1'b1,
                       tskwc_pkg::TIME_W'(stamp_span) * 37'd100 / 37'd18);
        run_random(300);

        if (summary.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[ts_keyframe_window_classifier_unit.f]
+incdir+rtl/core
rtl/core/tskwc_pkg.sv
rtl/core/tskwc_stream_if.sv
rtl/core/ts_keyframe_window_classifier_unit.sv
dv/tb_top.sv
